// ===== hdl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg: shared types, codes and step tables of the LED pattern sequencer
// Holds the command codes, the step row format and the per-color step tables.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  localparam int COUNT_BITS = 8;
  localparam int STEP_BITS  = 4;
  localparam int FUNC_BITS  = 2;
  localparam int PAT_BITS   = 3;

  // Command codes carried in the func field.
  localparam logic [FUNC_BITS-1:0] FUNC_TICK      = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_START_RED = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_START_BLU = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_ALL_OFF   = 2'd3;

  // Channel identifiers.
  localparam logic CHAN_RED  = 1'b0;
  localparam logic CHAN_BLUE = 1'b1;

  typedef struct packed {
    logic                  level;
    logic [STEP_BITS-1:0]  next;
    logic [COUNT_BITS-1:0] count;
  } step_row_t;

  typedef struct packed {
    logic tick;
    logic start;
    logic clear;
  } chan_cmd_t;

  typedef struct packed {
    logic on;
    logic busy;
  } chan_stat_t;

  function automatic step_row_t make_row(input logic lvl, input int nxt, input int cnt);
    step_row_t r;
    r.level = lvl;
    r.next  = STEP_BITS'(nxt);
    r.count = COUNT_BITS'(cnt);
    return r;
  endfunction

  function automatic step_row_t red_row(input logic [STEP_BITS-1:0] step);
    step_row_t r;
    case (step)
      4'd1:    r = make_row(1'b1, 2, 20);
      4'd3:    r = make_row(1'b1, 4, 100);
      4'd4:    r = make_row(1'b0, 3, 100);
      4'd5:    r = make_row(1'b1, 6, 10);
      4'd6:    r = make_row(1'b0, 7, 20);
      4'd7:    r = make_row(1'b1, 8, 10);
      4'd8:    r = make_row(1'b0, 9, 20);
      4'd9:    r = make_row(1'b1, 10, 10);
      4'd11:   r = make_row(1'b1, 12, 20);
      4'd12:   r = make_row(1'b0, 11, 40);
      4'd13:   r = make_row(1'b1, 14, 100);
      default: r = make_row(1'b0, 0, 0);
    endcase
    return r;
  endfunction

  function automatic step_row_t blue_row(input logic [STEP_BITS-1:0] step);
    step_row_t r;
    case (step)
      4'd1:    r = make_row(1'b1, 2, 20);
      4'd3:    r = make_row(1'b1, 4, 200);
      4'd5:    r = make_row(1'b1, 6, 100);
      4'd6:    r = make_row(1'b0, 5, 100);
      4'd7:    r = make_row(1'b1, 8, 10);
      4'd8:    r = make_row(1'b0, 9, 20);
      4'd9:    r = make_row(1'b1, 10, 10);
      4'd10:   r = make_row(1'b0, 11, 20);
      4'd11:   r = make_row(1'b1, 12, 10);
      4'd13:   r = make_row(1'b1, 14, 30);
      default: r = make_row(1'b0, 0, 0);
    endcase
    return r;
  endfunction

  function automatic logic [STEP_BITS-1:0] red_first(input logic [PAT_BITS-1:0] pat);
    logic [STEP_BITS-1:0] s;
    case (pat)
      3'd1:    s = 4'd1;
      3'd2:    s = 4'd3;
      3'd3:    s = 4'd5;
      3'd4:    s = 4'd11;
      3'd5:    s = 4'd13;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [STEP_BITS-1:0] blue_first(input logic [PAT_BITS-1:0] pat);
    logic [STEP_BITS-1:0] s;
    case (pat)
      3'd1:    s = 4'd1;
      3'd2:    s = 4'd3;
      3'd3:    s = 4'd5;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd13;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lps_channel.sv =====
// ----------------------------------------------------------------------------
// lps_channel: one LED channel of the pattern sequencer
// Holds step, countdown and level of one color and advances them per command.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_channel (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         chan_id,
  input  wire lps_pkg::chan_cmd_t           cmd,
  input  wire logic [lps_pkg::PAT_BITS-1:0] pattern,
  output lps_pkg::chan_stat_t               stat_nxt
);
  import lps_pkg::*;

  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  level_r, level_nxt;

  logic [STEP_BITS-1:0]  sel_step;
  step_row_t             row;
  logic                  expire;

  always_comb begin
    sel_step = cmd.start ? ((chan_id == CHAN_BLUE) ? blue_first(pattern) : red_first(pattern))
                         : step_r;
    row      = (chan_id == CHAN_BLUE) ? blue_row(sel_step) : red_row(sel_step);
    // An armed countdown at one runs out on this tick.
    expire   = cmd.tick && (cnt_r == COUNT_BITS'(1));

    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    if (cmd.clear) begin
      step_nxt  = '0;
      cnt_nxt   = '0;
      level_nxt = 1'b0;
    end else if (cmd.start || expire) begin
      step_nxt  = row.next;
      cnt_nxt   = row.count;
      level_nxt = row.level;
    end else if (cmd.tick && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - COUNT_BITS'(1);
    end

    stat_nxt.on   = level_nxt;
    stat_nxt.busy = (cnt_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      cnt_r   <= '0;
      level_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/two_channel_led_pattern_sequencer_unit.sv =====
// The result of an accepted input transaction is registered and shows on out_*
// in the next cycle. Throughput: one transaction per cycle unless the output
// stalls; the channel state updates at the accepting edge, so a command or tick
// may follow in the very next cycle. The result register doubles as the output
// stage: input is taken whenever it is empty or is being drained in the same cycle.
// Reset (rst_n low, synchronous): both channels off, countdowns disarmed, no result.
// ----------------------------------------------------------------------------
// two_channel_led_pattern_sequencer_unit: red/blue LED blink pattern sequencer
// Decodes commands and ticks, drives two channel sequencers, registers status.
// ----------------------------------------------------------------------------
`default_nettype none

module two_channel_led_pattern_sequencer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [1:0] func, [4:2] pattern, [7:5] zero
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] red_on, [1] blue_on, [2] red_busy,
                                      // [3] blue_busy, [7:4] zero
);
  import lps_pkg::*;

  logic                  accept;
  logic [FUNC_BITS-1:0]  func;
  logic [PAT_BITS-1:0]   pattern;
  chan_cmd_t             red_cmd, blue_cmd;
  chan_stat_t            red_stat, blue_stat;

  logic                  out_valid_r;
  logic [3:0]            out_data_r;

  // The single output register frees up whenever the sink takes its contents.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign func    = in_tdata[FUNC_BITS-1:0];
  assign pattern = in_tdata[FUNC_BITS +: PAT_BITS];

  // A tick and all-off reach both channels; a start reaches only its own color.
  always_comb begin
    red_cmd.tick   = accept && (func == FUNC_TICK);
    red_cmd.start  = accept && (func == FUNC_START_RED);
    red_cmd.clear  = accept && (func == FUNC_ALL_OFF);
    blue_cmd.tick  = red_cmd.tick;
    blue_cmd.start = accept && (func == FUNC_START_BLU);
    blue_cmd.clear = red_cmd.clear;
  end

  lps_channel u_red (
    .clk      (clk),
    .rst_n    (rst_n),
    .chan_id  (CHAN_RED),
    .cmd      (red_cmd),
    .pattern  (pattern),
    .stat_nxt (red_stat)
  );

  lps_channel u_blue (
    .clk      (clk),
    .rst_n    (rst_n),
    .chan_id  (CHAN_BLUE),
    .cmd      (blue_cmd),
    .pattern  (pattern),
    .stat_nxt (blue_stat)
  );

  // Result register: loads the post-command status with each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {blue_stat.busy, red_stat.busy, blue_stat.on, red_stat.on};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the two-channel LED pattern sequencer
// Sends commands and ticks over the input stream and checks every status
// transaction on the output stream against an in-bench model of the red and
// blue pattern sequencers, under random idling and long output stalls.
// ----------------------------------------------------------------------------

module tb_top;
  import lps_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  // The longest deliberate stall below is HOLD_CYCLES, well under this.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [1:0] func, [4:2] pattern, [7:5] zero
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [0] red_on, [1] blue_on, [2] red_busy,
                                   // [3] blue_busy, [7:4] zero

  always #2 clk = ~clk;

  two_channel_led_pattern_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer model. Each channel holds the step it will run next, its
  // countdown in ticks and the LED level. Running a step copies the step's
  // level, moves to its successor and reloads the countdown; a zero reload
  // means the pattern is over and the channel ignores further ticks.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic                  lit;
    logic [STEP_BITS-1:0]  follow;
    logic [COUNT_BITS-1:0] dwell;
  } phase_t;

  typedef struct packed {
    logic [STEP_BITS-1:0]  ph;
    logic [COUNT_BITS-1:0] cnt;
    logic                  lit;
  } led_chan_t;

  led_chan_t  red_chan  = '0;
  led_chan_t  blue_chan = '0;

  // Expected status nibbles {blue_busy, red_busy, blue_on, red_on}, oldest first.
  logic [3:0] led_status_q[$];

  function automatic phase_t phase_of(input logic lit, input int nxt, input int dw);
    phase_t p;
    p.lit    = lit;
    p.follow = nxt[STEP_BITS-1:0];
    p.dwell  = dw[COUNT_BITS-1:0];
    return p;
  endfunction

  // Red steps: 1-2 single 200 ms pulse, 3-4 endless 1 s / 1 s, 5-10 three
  // short flashes, 11-12 endless 200 / 400 ms, 13-14 single 1 s pulse.
  // Anything not listed is the dark, idle step.
  function automatic phase_t red_phase(input logic [STEP_BITS-1:0] ph);
    case (ph)
      4'd1:    return phase_of(1'b1, 2, 20);
      4'd3:    return phase_of(1'b1, 4, 100);
      4'd4:    return phase_of(1'b0, 3, 100);
      4'd5:    return phase_of(1'b1, 6, 10);
      4'd6:    return phase_of(1'b0, 7, 20);
      4'd7:    return phase_of(1'b1, 8, 10);
      4'd8:    return phase_of(1'b0, 9, 20);
      4'd9:    return phase_of(1'b1, 10, 10);
      4'd11:   return phase_of(1'b1, 12, 20);
      4'd12:   return phase_of(1'b0, 11, 40);
      4'd13:   return phase_of(1'b1, 14, 100);
      default: return phase_of(1'b0, 0, 0);
    endcase
  endfunction

  // Blue steps: 1-2 single 200 ms pulse, 3-4 single 2 s pulse, 5-6 endless
  // 1 s / 1 s, 7-12 three short flashes, 13-14 single 300 ms pulse.
  function automatic phase_t blue_phase(input logic [STEP_BITS-1:0] ph);
    case (ph)
      4'd1:    return phase_of(1'b1, 2, 20);
      4'd3:    return phase_of(1'b1, 4, 200);
      4'd5:    return phase_of(1'b1, 6, 100);
      4'd6:    return phase_of(1'b0, 5, 100);
      4'd7:    return phase_of(1'b1, 8, 10);
      4'd8:    return phase_of(1'b0, 9, 20);
      4'd9:    return phase_of(1'b1, 10, 10);
      4'd10:   return phase_of(1'b0, 11, 20);
      4'd11:   return phase_of(1'b1, 12, 10);
      4'd13:   return phase_of(1'b1, 14, 30);
      default: return phase_of(1'b0, 0, 0);
    endcase
  endfunction

  // First step of each pattern number; numbers 6 and 7 fall back to off.
  function automatic logic [STEP_BITS-1:0] entry_step(input logic chan,
                                                      input logic [PAT_BITS-1:0] pat);
    case (pat)
      3'd1:    return 4'd1;
      3'd2:    return 4'd3;
      3'd3:    return 4'd5;
      3'd4:    return (chan == CHAN_BLUE) ? 4'd7 : 4'd11;
      3'd5:    return 4'd13;
      default: return 4'd0;
    endcase
  endfunction

  function automatic led_chan_t take_phase(input led_chan_t c, input logic chan);
    phase_t p;
    p = (chan == CHAN_BLUE) ? blue_phase(c.ph) : red_phase(c.ph);
    c.lit = p.lit;
    c.ph  = p.follow;
    c.cnt = p.dwell;
    return c;
  endfunction

  function automatic led_chan_t tick_chan(input led_chan_t c, input logic chan);
    if (c.cnt == '0) return c;
    c.cnt = c.cnt - 1'b1;
    if (c.cnt == '0) c = take_phase(c, chan);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Run statistics for the closing summary.
  // --------------------------------------------------------------------------
  int n_sent      = 0;
  int n_ticks     = 0;
  int n_starts    = 0;
  int n_all_off   = 0;
  int n_red_done  = 0;
  int n_blue_done = 0;
  int n_checked   = 0;
  int n_errors    = 0;

  // Updates the model for one accepted input transaction and queues the
  // status the block must report for it.
  task automatic apply_command(input logic [FUNC_BITS-1:0] func,
                               input logic [PAT_BITS-1:0] pat);
    logic red_was, blue_was;
    red_was  = (red_chan.cnt != '0);
    blue_was = (blue_chan.cnt != '0);
    case (func)
      FUNC_TICK: begin
        red_chan  = tick_chan(red_chan, CHAN_RED);
        blue_chan = tick_chan(blue_chan, CHAN_BLUE);
        n_ticks++;
        if (red_was && red_chan.cnt == '0) n_red_done++;
        if (blue_was && blue_chan.cnt == '0) n_blue_done++;
      end
      FUNC_START_RED: begin
        red_chan.ph = entry_step(CHAN_RED, pat);
        red_chan    = take_phase(red_chan, CHAN_RED);
        n_starts++;
      end
      FUNC_START_BLU: begin
        blue_chan.ph = entry_step(CHAN_BLUE, pat);
        blue_chan    = take_phase(blue_chan, CHAN_BLUE);
        n_starts++;
      end
      FUNC_ALL_OFF: begin
        red_chan  = '0;
        blue_chan = '0;
        n_all_off++;
      end
    endcase
    led_status_q.push_back({blue_chan.cnt != '0, red_chan.cnt != '0,
                            blue_chan.lit, red_chan.lit});
  endtask

  // --------------------------------------------------------------------------
  // Sender. Each call starts at a rising edge, may idle first, then offers
  // one transaction and returns at the edge where it is accepted. Valid is
  // left high on return so that back-to-back items never toggle it in one
  // time step.
  // --------------------------------------------------------------------------
  int send_idle_pct = 26;

  task automatic send_item(input logic [FUNC_BITS-1:0] func,
                           input logic [PAT_BITS-1:0] pat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, pat, func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_command(func, pat);
    n_sent++;
  endtask

  task automatic wait_drained();
    while (led_status_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Ready is drawn at random each cycle unless a long hold-off has
  // been requested. The test asks for a hold-off by bumping holds_asked with
  // a nonblocking write, so this process always sees the request at the next
  // edge, not the current one, independent of process order.
  // --------------------------------------------------------------------------
  int recv_idle_pct  = 57;
  int holds_asked    = 0;
  int holds_granted  = 0;
  int hold_left      = 0;

  always @(posedge clk) begin
    if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= HOLD_CYCLES;
      out_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Checker. Every accepted status transaction is matched against the oldest
  // expectation, one field at a time in the report.
  // --------------------------------------------------------------------------
  logic [3:0] want_status;

  task automatic report_error(input string what, input logic [3:0] want,
                              input logic [3:0] got);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display({"tb: %s at %0t: red_on %b/%b blue_on %b/%b red_busy %b/%b",
                " blue_busy %b/%b (exp/got)"},
               what, $realtime, want[0], got[0], want[1], got[1],
               want[2], got[2], want[3], got[3]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (led_status_q.size() == 0) begin
        report_error("unexpected status", 4'bxxxx, out_tdata[3:0]);
      end else begin
        want_status = led_status_q.pop_front();
        n_checked++;
        if (out_tdata[3:0] !== want_status)
          report_error("status mismatch", want_status, out_tdata[3:0]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hang shows up as a long run of cycles with no handshake on
  // either stream.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired after %0d idle cycles, %0d results pending",
               quiet_cycles, led_status_q.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Short hand-picked sequence: every command code, every pattern number on
  // both channels (including the two out-of-range ones), a tick while idle,
  // junk in the pattern field of ticks and all-off, and a restart of a
  // running pattern.
  task automatic test_directed();
    send_item(FUNC_TICK, 3'd0);
    send_item(FUNC_TICK, 3'd7);
    for (int p = 1; p < 8; p++) send_item(FUNC_START_RED, p[PAT_BITS-1:0]);
    send_item(FUNC_START_RED, 3'd0);
    for (int p = 1; p < 8; p++) send_item(FUNC_START_BLU, p[PAT_BITS-1:0]);
    send_item(FUNC_START_BLU, 3'd0);
    send_item(FUNC_START_RED, 3'd2);
    send_item(FUNC_START_BLU, 3'd3);
    send_item(FUNC_TICK, 3'd5);
    send_item(FUNC_START_RED, 3'd4);
    send_item(FUNC_ALL_OFF, 3'd5);
    send_item(FUNC_START_BLU, 3'd5);
    send_item(FUNC_TICK, 3'd2);
  endtask

  function automatic logic [FUNC_BITS-1:0] FUNC_LL_START();
    return ($urandom_range(1) == 1) ? FUNC_START_BLU : FUNC_START_RED;
  endfunction

  // Random episodes: start one or both channels on a random pattern, then
  // run a stream of ticks long enough to walk through the steps. About four
  // episodes in ten run a long stream so the longest single pulses can reach their
  // end. A few percent of the stream is noise: restarts and all-off.
  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input int n_items);
    int stop_at;
    int ticks;
    int roll;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      send_item(FUNC_START_RED, PAT_BITS'($urandom_range(7)));
      if ($urandom_range(1) == 1) send_item(FUNC_START_BLU, PAT_BITS'($urandom_range(7)));
      ticks = ($urandom_range(9) < 6) ? $urandom_range(5, 60) : $urandom_range(100, 260);
      for (int i = 0; i < ticks && n_sent < stop_at; i++) begin
        roll = $urandom_range(99);
        if (roll < 93)
          send_item(FUNC_TICK, PAT_BITS'($urandom_range(7)));
        else if (roll < 98)
          send_item(FUNC_LL_START(), PAT_BITS'($urandom_range(7)));
        else
          send_item(FUNC_ALL_OFF, PAT_BITS'($urandom_range(7)));
      end
    end
  endtask

  // The receiver stops for a long stretch while the sender keeps offering,
  // so the output register fills and the block must stall its input.
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    holds_asked   <= holds_asked + 1;
    send_item(FUNC_START_RED, 3'd3);
    send_item(FUNC_START_BLU, 3'd4);
    for (int i = 0; i < 30; i++) send_item(FUNC_TICK, PAT_BITS'($urandom_range(7)));
  endtask

  // The sender goes quiet until every outstanding status has been seen,
  // then resumes on an emptied pipeline.
  task automatic test_sender_drain();
    send_idle_pct = 0;
    recv_idle_pct <= 26;
    send_item(FUNC_START_BLU, 3'd1);
    send_item(FUNC_TICK, 3'd0);
    in_tvalid <= 1'b0;
    wait_drained();
    @(posedge clk);
    for (int i = 0; i < 20; i++) send_item(FUNC_TICK, 3'd0);
    send_item(FUNC_ALL_OFF, 3'd0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_phase(26, 57, 390);
    test_random_phase(57, 26, 390);
    test_random_phase(0, 0, 390);
    test_output_holdoff();
    test_sender_drain();

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (led_status_q.size() != 0) begin
      n_errors++;
      $display("tb: %0d expected results never arrived", led_status_q.size());
    end

    $display({"tb: %0d commands sent (%0d ticks, %0d pattern starts, %0d all-off),",
              " %0d results checked"},
             n_sent, n_ticks, n_starts, n_all_off, n_checked);
    $display("tb: patterns run to completion: red %0d, blue %0d; errors %0d",
             n_red_done, n_blue_done, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
